// File: rtl/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg: shared types and constants for the radix digit converter
// Command and status groups between the controller and the datapath, plus the
// fixed digit width and radix limits.
// ----------------------------------------------------------------------------
package itrd_pkg;

   localparam int DIGIT_W = 6;

   localparam logic [DIGIT_W-1:0] RADIX_MIN     = 6'd2;
   localparam logic [DIGIT_W-1:0] RADIX_MAX     = 6'd36;
   localparam logic [DIGIT_W-1:0] RADIX_DEFAULT = 6'd10;

   // controller to datapath
   typedef struct packed {
      logic load;    // latch magnitude, sign and radix, clear counters
      logic step;    // one restoring division step
      logic store;   // write the finished digit, start the next one unless the quotient is zero
      logic read;    // read one digit from the buffer, most significant first
   } itrd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_bit;   // final division step of this digit
      logic q_zero;     // quotient is zero, no more digits
      logic rd_zero;    // read pointer at the least significant digit
   } itrd_status_type;

endpackage

// File: rtl/itrd_ram.sv
// ----------------------------------------------------------------------------
// itrd_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module itrd_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/itrd_datapath.sv
// ----------------------------------------------------------------------------
// itrd_datapath: magnitude, restoring divider and digit buffer
// Divides the magnitude by the radix one quotient bit per cycle, stores each
// remainder as a digit and plays the digits back in reverse order.
// ----------------------------------------------------------------------------
module itrd_datapath
   import itrd_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  itrd_cmd_type                  cmd,
   output itrd_status_type               status,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [DIGIT_W-1:0]            csr_radix,
   output logic                          rsp_strobe,
   output logic [DIGIT_W-1:0]            rsp_digit,
   output logic                          rsp_is_negative,
   output logic                          rsp_last
);

   localparam int MAG_W  = VALUE_WIDTH - 1;
   localparam int ADDR_W = $clog2(MAG_W);

   logic [DIGIT_W-1:0] radix_cfg_ff;
   logic [DIGIT_W-1:0] radix_ff;
   logic [DIGIT_W-1:0] radix_eff;
   logic               neg_ff;
   logic [MAG_W-1:0]   q_ff, q_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [ADDR_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0]  wr_ff;
   logic [ADDR_W-1:0]  rd_ff;
   logic               strobe_ff;
   logic               last_ff;
   logic [MAG_W-1:0]   mag;
   logic [VALUE_WIDTH-1:0] negated;
   logic [DIGIT_W:0]   trial;
   logic               ge;

   assign radix_eff = (radix_cfg_ff < RADIX_MIN || radix_cfg_ff > RADIX_MAX)
                      ? RADIX_DEFAULT : radix_cfg_ff;

   // magnitude, the most negative value saturates to the largest positive
   assign negated = ~req_value + VALUE_WIDTH'(1);
   always_comb begin
      if (!req_value[VALUE_WIDTH-1]) begin
         mag = req_value[MAG_W-1:0];
      end else if (req_value[MAG_W-1:0] == '0) begin
         mag = '1;
      end else begin
         mag = negated[MAG_W-1:0];
      end
   end

   // restoring division step
   assign trial  = {rem_ff, q_ff[MAG_W-1]};
   assign ge     = trial >= {1'b0, radix_ff};
   assign rem_in = ge ? DIGIT_W'(trial - {1'b0, radix_ff}) : trial[DIGIT_W-1:0];
   assign q_in   = {q_ff[MAG_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_cfg_ff <= RADIX_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         radix_cfg_ff <= csr_radix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ff     <= '0;
         rd_ff     <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= cmd.read;
         last_ff   <= cmd.read && status.rd_zero;
         if (cmd.load) begin
            cnt_ff <= '0;
            wr_ff  <= '0;
         end else if (cmd.step) begin
            cnt_ff <= cnt_ff + ADDR_W'(1);
         end else if (cmd.store) begin
            cnt_ff <= '0;
            if (status.q_zero) begin
               rd_ff <= wr_ff;
            end else begin
               wr_ff <= wr_ff + ADDR_W'(1);
            end
         end else if (cmd.read) begin
            rd_ff <= rd_ff - ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff     <= mag;
         rem_ff   <= '0;
         neg_ff   <= req_value[VALUE_WIDTH-1];
         radix_ff <= radix_eff;
      end else if (cmd.step) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end else if (cmd.store) begin
         rem_ff <= '0;
      end
   end

   itrd_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAG_W)
   ) u_digits (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (wr_ff),
      .wr_data (rem_ff),
      .rd_en   (cmd.read),
      .rd_addr (rd_ff),
      .rd_data (rsp_digit)
   );

   assign status.last_bit = cnt_ff == ADDR_W'(MAG_W - 1);
   assign status.q_zero   = q_ff == '0;
   assign status.rd_zero  = rd_ff == '0;

   assign rsp_strobe      = strobe_ff;
   assign rsp_is_negative = neg_ff;
   assign rsp_last        = last_ff;

endmodule

// File: rtl/itrd_ctrl.sv
// ----------------------------------------------------------------------------
// itrd_ctrl: sequencing of the radix digit converter
// Runs the division steps of each digit, stores the digit, then plays the
// stored digits back.
// ----------------------------------------------------------------------------
module itrd_ctrl
   import itrd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  itrd_status_type status,
   output itrd_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_STORE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.last_bit) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.q_zero ? ST_EMIT : ST_DIV;
         end
         ST_EMIT: begin
            cmd.read = 1'b1;
            if (status.rd_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

// File: rtl/int_to_radix_digits.sv
// ----------------------------------------------------------------------------
// int_to_radix_digits: signed integer to radix 2..36 digit conversion
// Emits the digits of the magnitude most significant first, each with the
// sign flag and a marker on the final digit.
//
//   channel   ports                                   handshake
//   request   start, busy, req_value                  start high, busy low
//   result    rsp_strobe, rsp_digit, rsp_is_negative, one-cycle strobe,
//             rsp_last                                no back-pressure
//   csr       csr_valid, csr_ready, csr_radix         valid and ready
//
// while busy is high, each digit goes through the one-bit-per-cycle restoring
// divider and is then stored, then one read per digit from the digit buffer
// plays the digits back
// the last strobe comes in the same cycle as busy falls
// synchronous reset returns the radix to 10 and the sequencer to idle
// the receiver cannot stall; csr_ready is always high
// ----------------------------------------------------------------------------
module int_to_radix_digits
   import itrd_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [DIGIT_W-1:0]            rsp_digit,
   output logic                          rsp_is_negative,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [DIGIT_W-1:0]            csr_radix
);

   itrd_cmd_type    cmd;
   itrd_status_type status;

   assign csr_ready = 1'b1;

   itrd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   itrd_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_radix       (csr_radix),
      .rsp_strobe      (rsp_strobe),
      .rsp_digit       (rsp_digit),
      .rsp_is_negative (rsp_is_negative),
      .rsp_last        (rsp_last)
   );

endmodule

// File: tb/int_to_radix_digits_checker.sv
// ----------------------------------------------------------------------------
// int_to_radix_digits_checker: digit stream scoreboard for the radix converter
// Follows csr writes to keep its own radix, predicts the digit sequence of
// every accepted request and compares each strobed digit, sign and last flag
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module int_to_radix_digits_checker
   import itrd_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   rsp_strobe,
   input  logic [DIGIT_W-1:0]     rsp_digit,
   input  logic                   rsp_is_negative,
   input  logic                   rsp_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [DIGIT_W-1:0]     csr_radix,
   output int                     mismatch_count,
   output int                     digits_pending
);

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               is_negative;
      logic               last;
   } digit_result_type;

   digit_result_type   expected_digits [$];
   logic [DIGIT_W-1:0] radix_reg;

   initial begin
      mismatch_count = 0;
      digits_pending = 0;
      radix_reg      = RADIX_DEFAULT;
   end

   function automatic logic [DIGIT_W-1:0] base_in_use(input logic [DIGIT_W-1:0] r);
      if (r < RADIX_MIN || r > RADIX_MAX) begin
         return RADIX_DEFAULT;
      end
      return r;
   endfunction

   // split the magnitude least significant first, then queue most significant first
   function automatic void queue_digits(input logic [VALUE_WIDTH-1:0] value,
                                        input logic [DIGIT_W-1:0]     base_narrow);
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] base;
      logic [DIGIT_W-1:0]     lsd_first [VALUE_WIDTH];
      int                     count;
      digit_result_type       entry;
      base = '0;
      base[DIGIT_W-1:0] = base_narrow;
      mag = value;
      if (value[VALUE_WIDTH-1]) begin
         mag = -value;
         // most negative value has no positive twin, clamp to the largest positive
         if (mag[VALUE_WIDTH-1]) begin
            mag = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
         end
      end
      count = 0;
      do begin
         lsd_first[count] = DIGIT_W'(mag % base);
         mag = mag / base;
         count++;
      end while (mag != 0);
      for (int k = count - 1; k >= 0; k--) begin
         entry.digit       = lsd_first[k];
         entry.is_negative = value[VALUE_WIDTH-1];
         entry.last        = (k == 0);
         expected_digits.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      digit_result_type want;
      if (reset) begin
         radix_reg = RADIX_DEFAULT;
         expected_digits.delete();
      end else begin
         // digits first: a new request may be taken on the edge of the last strobe
         if (rsp_strobe) begin
            if (expected_digits.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected digit %0d neg %0b last %0b", $time,
                           rsp_digit, rsp_is_negative, rsp_last);
               end
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit !== want.digit || rsp_is_negative !== want.is_negative ||
                   rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected digit %0d neg %0b last %0b, got %0d %0b %0b",
                              $time, want.digit, want.is_negative, want.last,
                              rsp_digit, rsp_is_negative, rsp_last);
                  end
               end
            end
         end
         // a request taken on the edge of a csr write still uses the old radix
         if (start && !busy) begin
            queue_digits(req_value, base_in_use(radix_reg));
         end
         if (csr_valid && csr_ready) begin
            radix_reg = csr_radix;
         end
      end
      digits_pending = expected_digits.size();
   end

endmodule

// File: tb/int_to_radix_digits_test.sv
// ----------------------------------------------------------------------------
// int_to_radix_digits_test: top level bench for the radix digit converter
// Drives directed edge values and random requests through a range of radix
// settings, including out-of-range ones, with random request gaps; the
// checker beside the block scores every digit.
// ----------------------------------------------------------------------------
module int_to_radix_digits_test
   import itrd_pkg::*;
();

   localparam int          VALUE_WIDTH = 32;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   rsp_strobe;
   logic [DIGIT_W-1:0]     rsp_digit;
   logic                   rsp_is_negative;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [DIGIT_W-1:0]     csr_radix = '0;

   int                     mismatch_count;
   int                     digits_pending;
   int unsigned            cycle_count = 0;
   bit                     gaps_on = 1'b0;
   logic [DIGIT_W-1:0]     radix_plan [10] = '{6'd2, 6'd36, 6'd16, 6'd3, 6'd0,
                                               6'd37, 6'd8, 6'd63, 6'd1, 6'd10};

   always #2 clock = ~clock;

   int_to_radix_digits #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_digit       (rsp_digit),
      .rsp_is_negative (rsp_is_negative),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_radix       (csr_radix)
   );

   int_to_radix_digits_checker #(.VALUE_WIDTH(VALUE_WIDTH)) scoreboard (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_digit       (rsp_digit),
      .rsp_is_negative (rsp_is_negative),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_radix       (csr_radix),
      .mismatch_count  (mismatch_count),
      .digits_pending  (digits_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 50) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 80);
   endfunction

   // mostly edge-heavy values: radix powers either side, extremes, single bits
   function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic [DIGIT_W-1:0] r);
      int                     roll;
      longint                 base;
      longint                 power;
      int                     steps;
      logic [VALUE_WIDTH-1:0] v;
      roll  = $urandom_range(0, 99);
      base  = (r < RADIX_MIN || r > RADIX_MAX) ? RADIX_DEFAULT : r;
      power = 1;
      if (roll < 40) begin
         v = $urandom;
      end else if (roll < 60) begin
         v = $urandom_range(0, 300);
      end else if (roll < 80) begin
         steps = $urandom_range(0, 30);
         while (steps > 0 && power * base <= 64'h7fff_ffff) begin
            power = power * base;
            steps--;
         end
         v = VALUE_WIDTH'(power - $urandom_range(0, 1));
      end else if (roll < 90) begin
         case ($urandom_range(0, 5))
            0:       v = 32'h7fff_ffff;
            1:       v = 32'h8000_0000;
            2:       v = 32'h8000_0001;
            3:       v = 32'h0000_0000;
            4:       v = 32'h0000_0001;
            default: v = 32'hffff_ffff;
         endcase
      end else begin
         v = 32'h1 << $urandom_range(0, 31);
      end
      if (roll >= 40 && roll < 80 && $urandom_range(0, 1) == 1) begin
         v = -v;
      end
      return v;
   endfunction

   // called just after a rising edge; returns on the edge that takes the request, or after a random gap
   task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
      int gap;
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_digits();
      start <= 1'b0;
      @(posedge clock);
      while (digits_pending != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_radix(input logic [DIGIT_W-1:0] r);
      csr_valid <= 1'b1;
      csr_radix <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default radix ten after reset
      send_value(32'd0);
      send_value(32'd1);
      send_value(-32'sd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'd99);
      send_value(32'd100);
      send_value(32'd1_000_000_000);
      send_value(32'h7fff_ffff);
      send_value(32'h8000_0001);
      send_value(32'h8000_0000);
      drain_digits();

      write_radix(6'd2);
      send_value(32'd2);
      send_value(32'h7fff_ffff);
      send_value(32'h8000_0000);
      drain_digits();

      write_radix(6'd36);
      send_value(32'd35);
      send_value(32'd36);
      send_value(-32'sd1296);
      send_value(32'h7fff_ffff);
      drain_digits();

      // out-of-range radix values fall back to ten
      write_radix(6'd1);
      send_value(32'd1234);
      drain_digits();
      write_radix(6'd63);
      send_value(-32'sd987);
      drain_digits();

      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 9) begin
            radix_plan[phase] = DIGIT_W'($urandom_range(0, 63));
         end
         write_radix(radix_plan[phase]);
         gaps_on = (phase % 3 != 2);
         for (int n = 0; n < 30; n++) begin
            send_value(pick_value(radix_plan[phase]));
         end
         drain_digits();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && digits_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/itrd_pkg.sv
rtl/itrd_ram.sv
rtl/itrd_datapath.sv
rtl/itrd_ctrl.sv
rtl/int_to_radix_digits.sv
tb/int_to_radix_digits_checker.sv
tb/int_to_radix_digits_test.sv
